// ===== hdl/point_to_polar_scan_binner_unit_assert.svh =====
// Assertion macros for the polar scan binner.
`ifndef POINT_TO_POLAR_SCAN_BINNER_UNIT_ASSERT_SVH
`define POINT_TO_POLAR_SCAN_BINNER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PSB_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define PSB_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define PSB_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define PSB_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ===== hdl/psb_pkg.sv =====
// ----------------------------------------------------------------------------
// psb_pkg
// Shared constants, types and tables of the polar scan binner.
// ----------------------------------------------------------------------------
`default_nettype none
package psb_pkg;
  localparam int NUM_BINS = 7200;
  localparam int BIN_W = 13;
  localparam int CORDIC_ITERS = 24;
  localparam int SQRT_STEPS = 16;

  localparam logic CMD_ACC  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] REG_HMIN = 2'd0;
  localparam logic [1:0] REG_HMAX = 2'd1;
  localparam logic [1:0] REG_RFLOOR = 2'd2;
  localparam logic [1:0] REG_RCEIL = 2'd3;

  localparam logic [15:0] RCEIL_RST = 16'd30000;

  typedef struct packed {
    logic        passed;
    logic        binned;
    logic [12:0] bin;
    logic [15:0] range;
  } res_t;

  function automatic logic [31:0] atan_tab(input logic [4:0] i);
    case (i)
      5'd0: atan_tab = 32'd536870912;  5'd1: atan_tab = 32'd316933406;
      5'd2: atan_tab = 32'd167458907;  5'd3: atan_tab = 32'd85004756;
      5'd4: atan_tab = 32'd42667331;   5'd5: atan_tab = 32'd21354465;
      5'd6: atan_tab = 32'd10679838;   5'd7: atan_tab = 32'd5340245;
      5'd8: atan_tab = 32'd2670163;    5'd9: atan_tab = 32'd1335087;
      5'd10: atan_tab = 32'd667544;    5'd11: atan_tab = 32'd333772;
      5'd12: atan_tab = 32'd166886;    5'd13: atan_tab = 32'd83443;
      5'd14: atan_tab = 32'd41722;     5'd15: atan_tab = 32'd20861;
      5'd16: atan_tab = 32'd10430;     5'd17: atan_tab = 32'd5215;
      5'd18: atan_tab = 32'd2608;      5'd19: atan_tab = 32'd1304;
      5'd20: atan_tab = 32'd652;       5'd21: atan_tab = 32'd326;
      5'd22: atan_tab = 32'd163;       5'd23: atan_tab = 32'd81;
      default: atan_tab = 32'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== hdl/psb_geom.sv =====
// ----------------------------------------------------------------------------
// psb_geom
// Iterative square root and CORDIC bearing, then bin index.
// ----------------------------------------------------------------------------
`default_nettype none
module psb_geom (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  output logic                    done,
  output logic [15:0]             range,
  output logic [31:0]             r2,
  output logic [13:0]             bin_raw
);
  import psb_pkg::*;

  localparam logic [2:0] G_IDLE = 3'd0;
  localparam logic [2:0] G_RUN  = 3'd1;
  localparam logic [2:0] G_MUL  = 3'd2;
  localparam logic [2:0] G_DONE = 3'd3;

  logic [2:0]  st_r;
  logic [4:0]  it_r;
  logic [31:0] rem_r;
  logic [15:0] root_r;
  logic [31:0] r2_r;
  logic signed [39:0] vx_r, vy_r;
  logic signed [33:0] z_r;
  logic        zero_y_r, neg_x_r;
  logic [32:0] t_r;

  logic [15:0] rbit;
  logic signed [39:0] dx, dy;
  logic signed [33:0] zt;
  logic [46:0] prod;

  always_comb begin
    rbit  = 16'd1 << (5'd15 - it_r[3:0]);
    dx = vy_r >>> it_r;
    dy = vx_r >>> it_r;
    zt = z_r + 34'sd2147483648;
    prod = {14'b0, t_r} * 47'(NUM_BINS);
  end

  // root bit test: (2*root*b + b*b) <= rem, via shifted forms
  logic [31:0] sq_sub;
  always_comb begin
    sq_sub = ({16'b0, root_r} << (5'd16 - {1'b0, it_r[3:0]})) + ({16'b0, rbit} * {16'b0, rbit});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= G_IDLE;
      it_r <= '0;
    end else begin
      case (st_r)
        G_IDLE: if (start) begin
          st_r <= G_RUN;
          it_r <= '0;
          r2_r <= 32'(x * x) + 32'(y * y);
          rem_r <= 32'(x * x) + 32'(y * y);
          root_r <= '0;
          zero_y_r <= (y == 0);
          neg_x_r <= x[15];
          if (x[15]) begin
            vx_r <= -(40'(x) <<< 16);
            vy_r <= -(40'(y) <<< 16);
            z_r <= y[15] ? -34'sd2147483648 : 34'sd2147483648;
          end else begin
            vx_r <= 40'(x) <<< 16;
            vy_r <= 40'(y) <<< 16;
            z_r <= '0;
          end
        end
        G_RUN: begin
          if (it_r < 5'(SQRT_STEPS) && sq_sub <= rem_r) begin
            rem_r <= rem_r - sq_sub;
            root_r <= root_r | rbit;
          end
          if (!vy_r[39]) begin
            vx_r <= vx_r + dx; vy_r <= vy_r - dy;
            z_r <= z_r + $signed({2'b0, atan_tab(it_r)});
          end else begin
            vx_r <= vx_r - dx; vy_r <= vy_r + dy;
            z_r <= z_r - $signed({2'b0, atan_tab(it_r)});
          end
          if (it_r == 5'(CORDIC_ITERS - 1)) st_r <= G_MUL;
          it_r <= it_r + 5'd1;
        end
        G_MUL: begin
          if (zero_y_r) t_r <= neg_x_r ? 33'h100000000 : 33'h080000000;
          else if (zt[33]) t_r <= '0;
          else if (zt > 34'sh100000000) t_r <= 33'h100000000;
          else t_r <= zt[32:0];
          st_r <= G_DONE;
        end
        G_DONE: begin
          st_r <= G_IDLE;
        end
        default: st_r <= G_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = ^{prod[46], prod[31:0]};
  assign done = (st_r == G_DONE);
  assign range = root_r;
  assign r2 = r2_r;
  assign bin_raw = prod[45:32];
endmodule
`default_nettype wire

// ===== hdl/point_to_polar_scan_binner_unit.sv =====
// ----------------------------------------------------------------------------
// point_to_polar_scan_binner_unit
// Gates 3D points by height and range and keeps the least range per bearing bin.
// ----------------------------------------------------------------------------
// channel | direction | fields
// in_     | input     | cmd, x_mm, y_mm, z_mm, read_bin
// out_    | output    | passed, binned, bin, range_mm
// cfg_    | input     | we, index, data
// A point stalls the input over CORDIC_ITERS CORDIC steps, the first SQRT_STEPS
// also sqrt steps, then clamp, bin multiply, and if binned a bin read and write.
// A read returns its bin and sets it to rceil; one past the bins returns rceil.
// After reset a clearing pass fills all 7200 bins with 30000.
// out_stall holds the result in the output register; the next item still runs
// and waits in S_OUT only if the register is still full when it finishes.
`default_nettype none
module point_to_polar_scan_binner_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd,
  input  wire logic signed [15:0] in_x_mm,
  input  wire logic signed [15:0] in_y_mm,
  input  wire logic signed [15:0] in_z_mm,
  input  wire logic [12:0] in_read_bin,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_passed,
  output logic             out_binned,
  output logic [12:0]      out_bin,
  output logic [15:0]      out_range_mm,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import psb_pkg::*;
`include "point_to_polar_scan_binner_unit_assert.svh"

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_GEO  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] st_r;
  logic signed [15:0] hmin_r, hmax_r;
  logic [15:0] rflo_r, rceil_r;
  logic [12:0] clr_r;
  logic cmd_r;
  logic signed [15:0] z_r;
  logic [12:0] rbin_r;
  logic [15:0] mem [NUM_BINS];
  logic [15:0] rd_q;
  res_t res_r;
  res_t out_r;
  logic out_vld_r;
  logic load_out;

  logic g_done;
  logic [15:0] g_range;
  logic [31:0] g_r2;
  logic [13:0] g_bin;
  logic pass_w;

  psb_geom u_geom (
    .clk(clk), .rst_n(rst_n),
    .start(in_valid && !in_stall && in_cmd == CMD_ACC),
    .x(in_x_mm), .y(in_y_mm),
    .done(g_done), .range(g_range), .r2(g_r2), .bin_raw(g_bin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hmin_r <= 16'sd135; hmax_r <= 16'sd1500;
      rflo_r <= 16'd250; rceil_r <= RCEIL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HMIN: hmin_r <= cfg_data;
        REG_HMAX: hmax_r <= cfg_data;
        REG_RFLOOR: rflo_r <= cfg_data;
        REG_RCEIL: rceil_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pass_w = (z_r >= hmin_r) && (z_r <= hmax_r) &&
                  (g_r2 >= 32'(rflo_r * rflo_r)) && (g_r2 <= 32'(rceil_r * rceil_r));

  // single bin memory: read in S_RD, written back in S_WB, the state after it
  logic mem_we;
  logic [12:0] mem_wa, mem_ra;
  logic [15:0] mem_wd;
  always_comb begin
    mem_we = 1'b0; mem_wa = clr_r; mem_wd = RCEIL_RST;
    mem_ra = rbin_r;
    if (st_r == S_CLR) mem_we = 1'b1;
    else if (st_r == S_WB) begin
      mem_wa = rbin_r;
      if (cmd_r == CMD_READ) begin
        mem_we = 1'b1; mem_wd = rceil_r;
      end else begin
        mem_we = res_r.binned && (res_r.range < rd_q); mem_wd = res_r.range;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0;
    end else begin
      case (st_r)
        S_CLR: begin
          if (clr_r == 13'(NUM_BINS - 1)) st_r <= S_IDLE;
          clr_r <= clr_r + 13'd1;
        end
        S_IDLE: if (in_valid) begin
          cmd_r <= in_cmd; z_r <= in_z_mm; rbin_r <= in_read_bin;
          if (in_cmd == CMD_READ) begin
            res_r <= '{passed: 1'b0, binned: 1'b0, bin: in_read_bin, range: rceil_r};
            st_r <= (in_read_bin < 13'(NUM_BINS)) ? S_RD : S_OUT;
          end else st_r <= S_GEO;
        end
        S_GEO: if (g_done) begin
          res_r.passed <= pass_w;
          res_r.binned <= pass_w && (g_bin < 14'(NUM_BINS));
          res_r.bin <= (pass_w && g_bin < 14'(NUM_BINS)) ? g_bin[12:0] : 13'd0;
          res_r.range <= g_range;
          rbin_r <= g_bin[12:0];
          st_r <= (pass_w && g_bin < 14'(NUM_BINS)) ? S_RD : S_OUT;
        end
        S_RD: st_r <= S_WB;
        S_WB: begin
          if (cmd_r == CMD_READ) res_r.range <= rd_q;
          st_r <= S_OUT;
        end
        S_OUT: if (load_out) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // output register: a waiting result holds up the next item only in S_OUT
  assign load_out = (st_r == S_OUT) && (!out_vld_r || !out_stall);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r <= 1'b1;
      out_r <= res_r;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  assign in_stall = (st_r != S_IDLE);
  assign out_valid = out_vld_r;
  assign out_passed = out_r.passed;
  assign out_binned = out_r.binned;
  assign out_bin = out_r.bin;
  assign out_range_mm = out_r.range;

  `PSB_ASSERT_IMP(a_bin_ok, clk, rst_n, out_valid && out_binned, out_bin < 13'(NUM_BINS), "bin out of range")
  `PSB_ASSERT_IMP(a_bin_pass, clk, rst_n, out_valid && out_binned, out_passed, "binned without pass")
  `PSB_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_r), "result lost")
endmodule
`default_nettype wire
